// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file of the frame receiver
// depends on a clk and an active-low arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, idle while reset is asserted
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication, idle while reset is asserted
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ----- sv/sfr_pkg.sv -----
// shared types and codes of the serial frame receiver
// no dependencies; used by sfr_step, the top level and the checker
`default_nettype none

package sfr_pkg;

	// parser phase, one-hot
	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_ID    = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_CHECK = 5'b10000
	} phase_t;

	// event codes of a result
	localparam logic [1:0] EV_NONE     = 2'd0;
	localparam logic [1:0] EV_PAYLOAD  = 2'd1;
	localparam logic [1:0] EV_GOOD     = 2'd2;
	localparam logic [1:0] EV_MISMATCH = 2'd3;

	// register selects, taken from paddr[2]
	localparam logic REG_HEAD_BYTE = 1'b0;
	localparam logic REG_ID_LIMIT  = 1'b1;

	// reset values of the registers
	localparam logic [7:0] HEAD_BYTE_RST = 8'd0;
	localparam logic [8:0] ID_LIMIT_RST  = 9'd256;

	// parser state carried from one byte to the next
	typedef struct packed {
		phase_t     phase;
		logic [7:0] running_sum;
		logic [7:0] held_id;
		logic [7:0] held_length;
		logic [7:0] bytes_seen;
	} state_t;

	// one result
	typedef struct packed {
		logic [1:0] event_res;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_id;
		logic [7:0] frame_length;
	} result_t;

	// configuration seen by the parser
	typedef struct packed {
		logic [7:0] head_byte;
		logic [8:0] id_limit;
	} cfg_t;

endpackage

`default_nettype wire

// ----- sv/sfr_step.sv -----
// per-byte next-state and result logic of the frame parser
// depends on sfr_pkg for the state, result and configuration types
`default_nettype none

module sfr_step (
	input  wire sfr_pkg::state_t  cur,
	input  wire logic [7:0]       rx_byte,
	input  wire sfr_pkg::cfg_t    cfg,
	output sfr_pkg::state_t       nxt,
	output sfr_pkg::result_t      res
);

	logic [7:0] sum_add;
	logic [7:0] seen_inc;

	assign sum_add  = cur.running_sum + rx_byte;
	assign seen_inc = cur.bytes_seen + 8'd1;

	// phase transitions and result event
	always_comb begin
		nxt               = cur;
		res.event_res     = sfr_pkg::EV_NONE;
		res.payload_byte  = 8'd0;
		res.payload_index = 8'd0;
		unique case (cur.phase)
			sfr_pkg::PH_HUNT: begin
				if (rx_byte == cfg.head_byte) begin
					nxt.running_sum = rx_byte;
					nxt.held_id     = 8'd0;
					nxt.held_length = 8'd0;
					nxt.bytes_seen  = 8'd0;
					nxt.phase       = sfr_pkg::PH_ID;
				end
			end
			sfr_pkg::PH_ID: begin
				if ({1'b0, rx_byte} < cfg.id_limit) begin
					nxt.held_id     = rx_byte;
					nxt.running_sum = sum_add;
					nxt.phase       = sfr_pkg::PH_LEN;
				end else begin
					// rejected id goes back to hunting without a head test
					nxt.phase = sfr_pkg::PH_HUNT;
				end
			end
			sfr_pkg::PH_LEN: begin
				nxt.held_length = rx_byte;
				nxt.running_sum = sum_add;
				nxt.phase       = (rx_byte == 8'd0) ? sfr_pkg::PH_CHECK : sfr_pkg::PH_DATA;
			end
			sfr_pkg::PH_DATA: begin
				res.event_res     = sfr_pkg::EV_PAYLOAD;
				res.payload_byte  = rx_byte;
				res.payload_index = cur.bytes_seen;
				nxt.running_sum   = sum_add;
				nxt.bytes_seen    = seen_inc;
				if (seen_inc >= cur.held_length) begin
					nxt.phase = sfr_pkg::PH_CHECK;
				end
			end
			sfr_pkg::PH_CHECK: begin
				res.event_res = (cur.running_sum == rx_byte) ? sfr_pkg::EV_GOOD
					: sfr_pkg::EV_MISMATCH;
				nxt.phase     = sfr_pkg::PH_HUNT;
			end
			default: begin
				nxt.phase = sfr_pkg::PH_HUNT;
			end
		endcase
		res.frame_id     = nxt.held_id;
		res.frame_length = nxt.held_length;
	end

endmodule

`default_nettype wire

// ----- sv/serial_frame_receiver.sv -----
// serial frame receiver top level: input register, parser step, result register
// depends on sfr_pkg and sfr_step
//
// usage:
//   rx channel (rx_valid, rx_stall, rx_byte) takes one received byte per request.
//   res channel (res_valid, res_stall, event_res, payload_byte, payload_index,
//   frame_id, frame_length) returns exactly one result per byte.
//   the APB port sets head_byte at address 0 and id_limit at address 4; write
//   only while no byte is in flight. pready is tied high, reads return the value.
// pipeline and throughput:
//   an accepted byte passes through the input register, then the result register;
//   one byte per cycle is sustained while res_stall is low; the parser state update
//   in sfr_step is combinational and sits between the two registers.
// reset:
//   arst_n clears both pipeline valids, returns the parser to head hunting with
//   sums and counts at zero, head_byte to 0 and id_limit to 256.
// stalls:
//   while res_stall holds a result, a byte can still enter an empty input register;
//   rx_stall rises only when both registers are full and the result is stalled.
`default_nettype none

module serial_frame_receiver (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// byte input
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	// result output
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [1:0]       event_res,
	output logic [7:0]       payload_byte,
	output logic [7:0]       payload_index,
	output logic [7:0]       frame_id,
	output logic [7:0]       frame_length,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	sfr_pkg::cfg_t    cfg_q;
	sfr_pkg::state_t  state_q;
	sfr_pkg::state_t  state_nxt;
	sfr_pkg::result_t res_nxt;
	sfr_pkg::result_t res_s2;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	logic             cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head_byte <= sfr_pkg::HEAD_BYTE_RST;
			cfg_q.id_limit  <= sfr_pkg::ID_LIMIT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == sfr_pkg::REG_HEAD_BYTE) begin
				cfg_q.head_byte <= pwdata[7:0];
			end else begin
				cfg_q.id_limit <= pwdata[8:0];
			end
		end
	end

	// register readback
	always_comb begin
		if (paddr[2] == sfr_pkg::REG_ID_LIMIT) begin
			prdata = {23'd0, cfg_q.id_limit};
		end else begin
			prdata = {24'd0, cfg_q.head_byte};
		end
	end

	// pipeline moves when the result register is empty or being taken
	assign advance  = !res_valid || !res_stall;
	assign rx_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser step
	sfr_step u_step (
		.cur     (state_q),
		.rx_byte (byte_s1),
		.cfg     (cfg_q),
		.nxt     (state_nxt),
		.res     (res_nxt)
	);

	// parser state, updated once per byte leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= sfr_pkg::PH_HUNT;
			state_q.running_sum <= 8'd0;
			state_q.held_id     <= 8'd0;
			state_q.held_length <= 8'd0;
			state_q.bytes_seen  <= 8'd0;
		end else if (advance && valid_s1) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign event_res     = res_s2.event_res;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign frame_id      = res_s2.frame_id;
	assign frame_length  = res_s2.frame_length;

endmodule

`default_nettype wire

// ----- sv/sfr_checker.sv -----
// port-level assertions for the serial frame receiver, bound to the top level
// depends on assert_macros.svh and sfr_pkg
`default_nettype none
`include "assert_macros.svh"

module sfr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_stall,
	input wire logic       res_valid,
	input wire logic       res_stall,
	input wire logic [1:0] event_res,
	input wire logic [7:0] payload_byte,
	input wire logic [7:0] payload_index,
	input wire logic [7:0] frame_length
);

	// an empty result register never pushes back on the byte input
	`ASSERT_IMPLIES(a_no_stall_when_empty, !res_valid, !rx_stall)

	// payload fields are zero unless the result carries a payload byte
	`ASSERT_IMPLIES(a_payload_zero, res_valid && (event_res != sfr_pkg::EV_PAYLOAD),
		(payload_byte == 8'd0) && (payload_index == 8'd0))

	// a payload byte lies inside the declared length
	`ASSERT_IMPLIES(a_index_in_frame, res_valid && (event_res == sfr_pkg::EV_PAYLOAD),
		payload_index < frame_length)

	// a stalled request holds its valid and event
	`ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(event_res))

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

`default_nettype wire
